// File: src/hth_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hth_pkg: shared types and constants
// Request codes, channel payloads, control state and the result handoff
// between the controller and the top level.
// ----------------------------------------------------------------------------
package hth_pkg;

	localparam int POS_W  = 11;   // queue position / footprint width
	localparam int CNT_W  = 64;   // hit and miss count width
	localparam int WIDE_W = 17;   // holds any position or capacity up to 65536

	localparam logic [POS_W-1:0] FP_RESET = 11'd1024;

	localparam logic [1:0] REQ_WRITE   = 2'd0;
	localparam logic [1:0] REQ_CONVERT = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] hit_count;
	} req_t;

	typedef struct packed {
		logic             status;
		logic [CNT_W-1:0] entry_value;
	} rsp_t;

	typedef logic [POS_W-1:0] cfg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDWAIT,
		ST_CONV
	} state_t;

	// result handoff from controller to output register
	typedef struct packed {
		logic load;
		logic status;
		logic from_mem;
	} res_t;

endpackage
`default_nettype wire

// File: src/hth_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hth_chan_if: valid/ready channel
// Generic handshake channel; payload type set per instance.
// ----------------------------------------------------------------------------
interface hth_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/hth_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hth_ram: simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hth_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: src/hth_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hth_ctrl: request sequencer
// Clearing pass, request decode, and the read-modify-write walk that
// turns hit counts into suffix sums.
// ----------------------------------------------------------------------------
module hth_ctrl #(
	parameter int MAX_PAGES = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              accept,
	input  wire hth_pkg::req_t                     req,
	input  wire logic [hth_pkg::WIDE_W-1:0]        fp_eff,
	output logic                                   idle,
	output logic                                   mem_we,
	output logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)-1:0] mem_waddr,
	output logic [hth_pkg::CNT_W-1:0]              mem_wdata,
	output logic                                   mem_re,
	output logic [((MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1)-1:0] mem_raddr,
	input  wire logic [hth_pkg::CNT_W-1:0]         mem_rdata,
	output hth_pkg::res_t                          res
);

	localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PAGES - 1);

	hth_pkg::state_t state_q, state_d;

	logic [AW-1:0]               clr_q;
	logic [AW-1:0]               cur_q;
	logic [hth_pkg::CNT_W-1:0]   sum_q;    // running miss count
	logic [hth_pkg::CNT_W-1:0]   sum_new;
	logic [hth_pkg::WIDE_W-1:0]  pos_wide;
	logic [hth_pkg::WIDE_W-1:0]  pos_m1;
	logic [hth_pkg::WIDE_W-1:0]  fp_m1;
	logic                        pos_zero;
	logic                        pos_ok;
	logic                        fp_zero;

	assign pos_wide = {{(hth_pkg::WIDE_W - hth_pkg::POS_W){1'b0}}, req.position};
	assign pos_m1   = pos_wide - hth_pkg::WIDE_W'(1);
	assign fp_m1    = fp_eff - hth_pkg::WIDE_W'(1);
	assign pos_zero = (req.position == '0);
	assign pos_ok   = !pos_zero && (pos_wide <= fp_eff);
	assign fp_zero  = (fp_eff == '0);
	assign sum_new  = sum_q + mem_rdata;
	assign idle     = (state_q == hth_pkg::ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hth_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ADDR) state_d = hth_pkg::ST_IDLE;
			end
			hth_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.req_type == hth_pkg::REQ_READ && pos_ok) begin
						state_d = hth_pkg::ST_RDWAIT;
					end else if (req.req_type == hth_pkg::REQ_CONVERT && !fp_zero) begin
						state_d = hth_pkg::ST_CONV;
					end
				end
			end
			hth_pkg::ST_RDWAIT: state_d = hth_pkg::ST_IDLE;
			hth_pkg::ST_CONV: begin
				if (cur_q == '0) state_d = hth_pkg::ST_IDLE;
			end
			default: state_d = hth_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = pos_m1[AW-1:0];
		res       = '0;
		case (state_q)
			hth_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			hth_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						hth_pkg::REQ_WRITE: begin
							mem_we     = pos_ok;
							mem_waddr  = pos_m1[AW-1:0];
							mem_wdata  = req.hit_count;
							res.load   = 1'b1;
							res.status = pos_ok ? hth_pkg::STATUS_OK : hth_pkg::STATUS_BAD;
						end
						hth_pkg::REQ_CONVERT: begin
							mem_re    = !fp_zero;
							mem_raddr = fp_m1[AW-1:0];
							res.load  = fp_zero;
						end
						hth_pkg::REQ_READ: begin
							mem_re     = pos_ok;
							res.load   = !pos_ok;
							res.status = (pos_ok || pos_zero) ? hth_pkg::STATUS_OK
							                                  : hth_pkg::STATUS_BAD;
						end
						default: begin
							res.load = 1'b1;
						end
					endcase
				end
			end
			hth_pkg::ST_RDWAIT: begin
				res.load     = 1'b1;
				res.from_mem = 1'b1;
			end
			hth_pkg::ST_CONV: begin
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = sum_new;
				mem_re    = (cur_q != '0);
				mem_raddr = cur_q - AW'(1);
				res.load  = (cur_q == '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hth_pkg::ST_CLEAR;
			clr_q   <= '0;
			cur_q   <= '0;
			sum_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == hth_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == hth_pkg::ST_IDLE && accept
			    && req.req_type == hth_pkg::REQ_CONVERT) begin
				sum_q <= '0;
				cur_q <= fp_m1[AW-1:0];
			end else if (state_q == hth_pkg::ST_CONV) begin
				sum_q <= sum_new;
				cur_q <= cur_q - AW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: src/hit_to_miss_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hit_to_miss_histogram: LRU hit histogram to miss histogram
// Stores per-position hit counts and converts them in place to suffix sums.
// ----------------------------------------------------------------------------
// Usage:
//  - req carries one request per transfer: write a hit count, convert the
//    whole histogram to misses, or read one entry. rsp returns exactly one
//    result (status, entry_value) per request, in order.
//  - cfg sets footprint_pages (highest valid position); always ready.
//    Values above MAX_PAGES act as MAX_PAGES. Write it only while idle.
//  - Results: write, bad position, position-zero read, unused code: the
//    result is registered straight from the transfer. Good read: one RAM
//    read, then the result register. Convert: the read-add-write walk over
//    the store, one entry per cycle through the RAM's two ports.
//  - One request at a time; req.ready drops while a read or convert is in
//    flight. A new request is taken while a result is handed off.
//  - Reset: a clearing pass zeroes all MAX_PAGES entries of the store,
//    during which req.ready is low; cfg is accepted throughout.
//  - rsp stall: the result holds in the output register and req.ready stays
//    low until rsp.ready is seen.
// ----------------------------------------------------------------------------
module hit_to_miss_histogram #(
	parameter int MAX_PAGES = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hth_chan_if.sink   req,
	hth_chan_if.source rsp,
	hth_chan_if.sink   cfg
);

	localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam logic [hth_pkg::WIDE_W-1:0] CAP = hth_pkg::WIDE_W'(MAX_PAGES);

	// footprint register
	logic [hth_pkg::POS_W-1:0]  fp_q;
	logic [hth_pkg::WIDE_W-1:0] fp_wide;
	logic [hth_pkg::WIDE_W-1:0] fp_eff;

	// controller <-> RAM
	logic                       ctrl_idle;
	logic                       mem_we;
	logic                       mem_re;
	logic [AW-1:0]              mem_waddr;
	logic [AW-1:0]              mem_raddr;
	logic [hth_pkg::CNT_W-1:0]  mem_wdata;
	logic [hth_pkg::CNT_W-1:0]  mem_rdata;
	hth_pkg::res_t              res;

	// output register
	logic                       rsp_valid_q;
	logic                       rsp_status_q;
	logic [hth_pkg::CNT_W-1:0]  rsp_value_q;

	logic                       req_xfer;
	logic                       slot_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= hth_pkg::FP_RESET;
		end else if (cfg.valid) begin
			fp_q <= cfg.data;
		end
	end

	// clamp to capacity
	assign fp_wide = {{(hth_pkg::WIDE_W - hth_pkg::POS_W){1'b0}}, fp_q};
	assign fp_eff  = (fp_wide > CAP) ? CAP : fp_wide;

	// take a request only when the result slot is empty or draining
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = ctrl_idle && slot_free;
	assign req_xfer  = req.valid && req.ready;

	hth_ctrl #(
		.MAX_PAGES (MAX_PAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (req_xfer),
		.req       (req.data),
		.fp_eff    (fp_eff),
		.idle      (ctrl_idle),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res       (res)
	);

	hth_ram #(
		.WIDTH (hth_pkg::CNT_W),
		.DEPTH (MAX_PAGES)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result register; controller loads it only when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			rsp_status_q <= res.status;
			rsp_value_q  <= res.from_mem ? mem_rdata : '0;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.data.status      = rsp_status_q;
	assign rsp.data.entry_value = rsp_value_q;

endmodule
`default_nettype wire

// File: src/hth_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hth_checker: port-level assertions
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module hth_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic [1:0]                 req_type,
	input wire logic [hth_pkg::POS_W-1:0]  req_position,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic                       rsp_status,
	input wire logic [hth_pkg::CNT_W-1:0]  rsp_value
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value))
		else $error("result changed while stalled");

	// no new request while a result is stuck
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken over a stalled result");

	// write answers on the next cycle with a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == hth_pkg::REQ_WRITE
		|=> rsp_valid && rsp_value == '0)
		else $error("write result missing or nonzero");

	// position zero reads as ok and zero
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == hth_pkg::REQ_READ && req_position == '0
		|=> rsp_valid && rsp_status == hth_pkg::STATUS_OK && rsp_value == '0)
		else $error("position zero read wrong");

endmodule

bind hit_to_miss_histogram hth_checker u_hth_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_type     (req.data.req_type),
	.req_position (req.data.position),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.data.status),
	.rsp_value    (rsp.data.entry_value)
);
`default_nettype wire
